// File: rtl/core/scfr_pkg.sv
// Package for the serial command frame receiver: frame geometry, command
// codes, action and status codes, and the packed result beat layout.
// No dependencies.
`timescale 1ns / 1ps

package scfr_pkg;

  localparam int unsigned FRAME_BYTES = 16;
  localparam int unsigned POS_W       = $clog2(FRAME_BYTES);
  localparam int unsigned WORD_CNT    = FRAME_BYTES / 2;
  localparam int unsigned WIDX_W      = $clog2(WORD_CNT);
  localparam int unsigned SUM_WORDS   = WORD_CNT - 1;  // checksum word excluded

  // Command words
  localparam logic [15:0] CMD_DISABLE     = 16'h0014;
  localparam logic [15:0] CMD_ENABLE      = 16'h0015;
  localparam logic [15:0] CMD_FREQ_UP     = 16'h0020;
  localparam logic [15:0] CMD_FREQ_DOWN   = 16'h0021;
  localparam logic [15:0] CMD_PHASE_UP    = 16'h0028;
  localparam logic [15:0] CMD_PHASE_DOWN  = 16'h0029;
  localparam logic [15:0] CMD_PHASE_SET   = 16'h002A;
  localparam logic [15:0] CMD_RELAY_CLOSE = 16'h0070;
  localparam logic [15:0] CMD_RELAY_OPEN  = 16'h0071;
  localparam logic [15:0] CMD_POWER_ON    = 16'h0080;
  localparam logic [15:0] CMD_POWER_OFF   = 16'h0081;

  typedef enum logic [3:0] {
    ACT_NONE        = 4'd0,
    ACT_DISABLE     = 4'd1,
    ACT_ENABLE      = 4'd2,
    ACT_FREQ_UP     = 4'd3,
    ACT_FREQ_DOWN   = 4'd4,
    ACT_PHASE_UP    = 4'd5,
    ACT_PHASE_DOWN  = 4'd6,
    ACT_PHASE_SET   = 4'd7,
    ACT_RELAY_CLOSE = 4'd8,
    ACT_RELAY_OPEN  = 4'd9,
    ACT_POWER_ON    = 4'd10,
    ACT_POWER_OFF   = 4'd11
  } action_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_CHECKSUM = 2'd1,
    ST_OVERRUN  = 2'd2
  } status_t;

  // Input kind flag
  localparam logic KIND_DATA    = 1'b0;
  localparam logic KIND_OVERRUN = 1'b1;

  // Result beat, packed LSB first from the bottom member up
  typedef struct packed {
    logic               pad;
    logic               enable_mode;
    logic [31:0]        float_argument_b;
    logic [31:0]        float_argument_a;
    logic signed [15:0] signed_argument;
    logic [15:0]        command_word;
    logic [15:0]        header_word;
    action_t            action;
    status_t            status;
  } result_t;

  localparam int unsigned RESULT_W = $bits(result_t);

  function automatic action_t decode_action(input logic [15:0] cmd);
    action_t act;
    begin
      case (cmd)
        CMD_DISABLE:     act = ACT_DISABLE;
        CMD_ENABLE:      act = ACT_ENABLE;
        CMD_FREQ_UP:     act = ACT_FREQ_UP;
        CMD_FREQ_DOWN:   act = ACT_FREQ_DOWN;
        CMD_PHASE_UP:    act = ACT_PHASE_UP;
        CMD_PHASE_DOWN:  act = ACT_PHASE_DOWN;
        CMD_PHASE_SET:   act = ACT_PHASE_SET;
        CMD_RELAY_CLOSE: act = ACT_RELAY_CLOSE;
        CMD_RELAY_OPEN:  act = ACT_RELAY_OPEN;
        CMD_POWER_ON:    act = ACT_POWER_ON;
        CMD_POWER_OFF:   act = ACT_POWER_OFF;
        default:         act = ACT_NONE;
      endcase
      return act;
    end
  endfunction

endpackage

// File: rtl/core/serial_command_frame_receiver.sv
// Serial command frame receiver top level: byte assembly, checksum, decode
// and a two-entry result buffer (output register plus skid entry).
// Depends on scfr_pkg.
`timescale 1ns / 1ps

// Accepts one beat per clock while in_tready is high: a received UART byte
// (in_tuser = 0) or a receive-overrun event (in_tuser = 1). Sixteen data bytes
// form one frame of eight little-endian words: header, command, float A (low word
// first), float B, signed argument, checksum. The checksum must equal the 16-bit
// wrapping sum of the first seven words. Each completed frame yields exactly one
// result beat with status ok, checksum error or overrun (overrun wins); overrun
// events and non-final bytes yield nothing. Rejected frames report zero payload
// and the unchanged enable-mode bit. Every input beat is processed in the cycle
// it is accepted, so while in_tready is high the sustained rate is one beat per
// clock; a final byte's result goes to the output register, or to the skid entry
// while that register holds an untaken beat. An output register plus one skid
// entry decouple the two sides: in_tready is a register and drops only when both
// entries hold results, and it comes back in the cycle after the downstream side
// takes a beat. The header is not checked; unknown commands give action none.
module serial_command_frame_receiver (
  input  logic                            clk,
  input  logic                            rst_n,
  // input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // [7:0] rx_byte
  input  logic                            in_tuser,   // [0] kind
  // result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [1:0] status, [5:2] action, [21:6] header_word, [37:22] command_word,
  // [53:38] signed_argument, [85:54] float_argument_a,
  // [117:86] float_argument_b, [118] enable_mode, [119] zero pad
  output logic [scfr_pkg::RESULT_W-1:0]   out_tdata
);

  import scfr_pkg::*;

  // Frame assembly state
  logic [POS_W-1:0]  byte_pos_r,   byte_pos_nxt;
  logic [7:0]        low_byte_r,   low_byte_nxt;
  logic [15:0]       run_sum_r,    run_sum_nxt;
  logic              overrun_r,    overrun_nxt;
  logic              mode_r,       mode_nxt;
  logic [15:0]       frame_words_r [SUM_WORDS];  // words 0..6; checksum compared live

  // Result buffer
  logic              out_valid_r,  out_valid_nxt;
  logic              skid_valid_r, skid_valid_nxt;
  result_t           out_data_r,   out_data_nxt;
  result_t           skid_data_r,  skid_data_nxt;

  logic              in_fire;
  logic              byte_fire;
  logic              last_byte;
  logic              odd_byte;
  logic [WIDX_W-1:0] widx;
  logic [15:0]       word;
  logic              out_fire;
  action_t           act;
  result_t           res;

  assign in_tready = !skid_valid_r;
  assign in_fire   = in_tvalid && in_tready;
  assign byte_fire = in_fire && (in_tuser == KIND_DATA);
  assign odd_byte  = byte_pos_r[0];
  assign widx      = byte_pos_r[POS_W-1:1];
  assign word      = {in_tdata, low_byte_r};
  assign last_byte = byte_fire && (byte_pos_r == POS_W'(FRAME_BYTES - 1));
  assign out_fire  = out_valid_r && out_tready;
  assign act       = decode_action(frame_words_r[1]);

  // Assembly next state
  always_comb begin
    byte_pos_nxt = byte_pos_r;
    low_byte_nxt = low_byte_r;
    run_sum_nxt  = run_sum_r;
    overrun_nxt  = overrun_r;
    mode_nxt     = mode_r;
    res          = '0;

    if (in_fire && (in_tuser == KIND_OVERRUN)) begin
      overrun_nxt = 1'b1;
    end else if (byte_fire) begin
      if (!odd_byte) begin
        low_byte_nxt = in_tdata;
        byte_pos_nxt = byte_pos_r + POS_W'(1);
      end else if (!last_byte) begin
        // words 0..6 all land here
        run_sum_nxt  = run_sum_r + word;
        byte_pos_nxt = byte_pos_r + POS_W'(1);
      end else begin
        // final byte: word is the checksum
        if (overrun_r) begin
          res.status = ST_OVERRUN;
        end else if (run_sum_r != word) begin
          res.status = ST_CHECKSUM;
        end else begin
          res.status           = ST_OK;
          res.action           = act;
          res.header_word      = frame_words_r[0];
          res.command_word     = frame_words_r[1];
          res.signed_argument  = frame_words_r[6];
          res.float_argument_a = {frame_words_r[3], frame_words_r[2]};
          res.float_argument_b = {frame_words_r[5], frame_words_r[4]};
          if (act == ACT_DISABLE) begin
            mode_nxt = 1'b0;
          end else if (act == ACT_ENABLE) begin
            mode_nxt = 1'b1;
          end
        end
        res.enable_mode = mode_nxt;
        byte_pos_nxt    = '0;
        run_sum_nxt     = '0;
        overrun_nxt     = 1'b0;
      end
    end
  end

  // Result buffer next state: skid drains first, new results never pass it
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;

    if (skid_valid_r) begin
      if (out_fire) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (last_byte) begin
      if (!out_valid_r || out_fire) begin
        out_data_nxt  = res;
        out_valid_nxt = 1'b1;
      end else begin
        skid_data_nxt  = res;
        skid_valid_nxt = 1'b1;
      end
    end else if (out_fire) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_pos_r   <= '0;
      low_byte_r   <= '0;
      run_sum_r    <= '0;
      overrun_r    <= 1'b0;
      mode_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      byte_pos_r   <= byte_pos_nxt;
      low_byte_r   <= low_byte_nxt;
      run_sum_r    <= run_sum_nxt;
      overrun_r    <= overrun_nxt;
      mode_r       <= mode_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // Payload storage, no reset
  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
    if (byte_fire && odd_byte && !last_byte) begin
      frame_words_r[widx] <= word;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
